// ----- hw/rtl/cvt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_pkg: shared definitions for the compacting value table
// Field widths, request and status codes, control word layout and the
// microcode program that steps the table datapath.
// ----------------------------------------------------------------------------
package cvt_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CAP_W   = 5;
    localparam int POS_W   = 4;
    localparam int FILL_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_READ_IDX,
        OP_ADVANCE,
        OP_SET_POS,
        OP_READ_NEXT,
        OP_SHIFT,
        OP_DEC,
        OP_APPEND,
        OP_ST_FULL,
        OP_ST_EMPTY,
        OP_ST_MISS,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_REQ,
        C_K_INS,
        C_K_SRCH,
        C_K_NOP,
        C_REM_EMPTY,
        C_IDX_END,
        C_MISS,
        C_SHIFT_END,
        C_FULL,
        C_OUT_BUSY
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Program addresses
    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_DISPATCH = 4'd1;
    localparam step_t S_CHK_NOP  = 4'd2;
    localparam step_t S_CHK_REM  = 4'd3;
    localparam step_t S_SCAN_RD  = 4'd4;
    localparam step_t S_SCAN_CMP = 4'd5;
    localparam step_t S_FOUND    = 4'd6;
    localparam step_t S_SH_RD    = 4'd7;
    localparam step_t S_SH_WR    = 4'd8;
    localparam step_t S_SH_DONE  = 4'd9;
    localparam step_t S_INS      = 4'd10;
    localparam step_t S_APPEND   = 4'd11;
    localparam step_t S_FULL     = 4'd12;
    localparam step_t S_EMPTY    = 4'd13;
    localparam step_t S_MISS     = 4'd14;
    localparam step_t S_EMIT     = 4'd15;

    // Control word: operation, jump condition, jump target
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t op;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic no_req;
        logic k_ins;
        logic k_srch;
        logic k_nop;
        logic rem_empty;
        logic idx_end;
        logic miss;
        logic shift_end;
        logic full;
        logic out_busy;
    } flags_t;

    // Microcode program; a word falls through to the next step when its
    // condition is false.
    function automatic uword_t ucode_rom(input step_t s);
        uword_t uw;
        unique case (s)
            S_IDLE:     uw = '{OP_TAKE,      C_NO_REQ,    S_IDLE};
            S_DISPATCH: uw = '{OP_NONE,      C_K_INS,     S_INS};
            S_CHK_NOP:  uw = '{OP_NONE,      C_K_NOP,     S_EMIT};
            S_CHK_REM:  uw = '{OP_NONE,      C_REM_EMPTY, S_EMPTY};
            S_SCAN_RD:  uw = '{OP_READ_IDX,  C_IDX_END,   S_MISS};
            S_SCAN_CMP: uw = '{OP_ADVANCE,   C_MISS,      S_SCAN_RD};
            S_FOUND:    uw = '{OP_SET_POS,   C_K_SRCH,    S_EMIT};
            S_SH_RD:    uw = '{OP_READ_NEXT, C_SHIFT_END, S_SH_DONE};
            S_SH_WR:    uw = '{OP_SHIFT,     C_ALWAYS,    S_SH_RD};
            S_SH_DONE:  uw = '{OP_DEC,       C_ALWAYS,    S_EMIT};
            S_INS:      uw = '{OP_NONE,      C_FULL,      S_FULL};
            S_APPEND:   uw = '{OP_APPEND,    C_ALWAYS,    S_EMIT};
            S_FULL:     uw = '{OP_ST_FULL,   C_ALWAYS,    S_EMIT};
            S_EMPTY:    uw = '{OP_ST_EMPTY,  C_ALWAYS,    S_EMIT};
            S_MISS:     uw = '{OP_ST_MISS,   C_ALWAYS,    S_EMIT};
            S_EMIT:     uw = '{OP_EMIT,      C_OUT_BUSY,  S_EMIT};
            default:    uw = '{OP_NONE,      C_ALWAYS,    S_IDLE};
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cvt_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_ifs: channel interfaces of the compacting value table
// Request, response and capacity write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface cvt_req_if;
    import cvt_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cvt_rsp_if;
    import cvt_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
    logic              is_full;
    modport source (output valid, output status, output position, output fill_count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input position, input fill_count,
                    input is_empty, input is_full, output ready);
endinterface

interface cvt_cfg_if;
    import cvt_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;
    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/cvt_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_seq: microcode sequencer
// Step counter over the program ROM; each word drives one datapath operation
// and optionally jumps on a datapath flag.
// ----------------------------------------------------------------------------
module cvt_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cvt_pkg::flags_t flags,
    output cvt_pkg::ctrl_t       ctrl
);
    import cvt_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   taken;

    // Fetch the current control word
    assign uw      = ucode_rom(pc_reg);
    assign ctrl.op = uw.op;

    // Evaluate the jump condition
    always_comb
    begin
        unique case (uw.cond)
            C_ALWAYS:    taken = 1'b1;
            C_NO_REQ:    taken = flags.no_req;
            C_K_INS:     taken = flags.k_ins;
            C_K_SRCH:    taken = flags.k_srch;
            C_K_NOP:     taken = flags.k_nop;
            C_REM_EMPTY: taken = flags.rem_empty;
            C_IDX_END:   taken = flags.idx_end;
            C_MISS:      taken = flags.miss;
            C_SHIFT_END: taken = flags.shift_end;
            C_FULL:      taken = flags.full;
            C_OUT_BUSY:  taken = flags.out_busy;
            default:     taken = 1'b0;
        endcase
    end

    // Jump or advance; the last step wraps to idle
    assign pc_next = taken ? uw.target : pc_reg + STEP_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cvt_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_dpath: table datapath
// Entry memory with one write and one registered read port, fill count,
// scan index, capacity register and the response output register.
// ----------------------------------------------------------------------------
module cvt_dpath #(
    parameter int DEPTH      = cvt_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = cvt_pkg::VALUE_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cvt_pkg::ctrl_t ctrl,
    output cvt_pkg::flags_t     flags,
    cvt_req_if.sink             req,
    cvt_rsp_if.source           rsp,
    cvt_cfg_if.sink             cfg
);
    import cvt_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    // Entry storage
    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;

    // Working registers
    logic [KIND_W-1:0]     kind_reg,   kind_next;
    logic [VALUE_BITS-1:0] val_reg,    val_next;
    logic [CW-1:0]         idx_reg,    idx_next;
    logic [CW-1:0]         count_reg,  count_next;
    logic [CAP_W-1:0]      cap_reg,    cap_next;
    status_t               status_reg, status_next;
    logic [POS_W-1:0]      pos_reg,    pos_next;

    // Response output register
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]     rsp_status_reg, rsp_status_next;
    logic [POS_W-1:0]      rsp_pos_reg, rsp_pos_next;
    logic [FILL_W-1:0]     rsp_fill_reg, rsp_fill_next;
    logic                  rsp_empty_reg, rsp_empty_next;
    logic                  rsp_full_reg, rsp_full_next;

    logic                  accept;
    logic                  hit;
    logic [CW-1:0]         idx_inc;
    logic [CMP_W-1:0]      cap_wide;
    logic [CMP_W-1:0]      cap_eff;
    logic                  full;
    logic                  empty;
    logic                  out_busy;
    logic                  k_ins;
    logic                  k_srch;
    logic                  k_rem;

    // Handshakes
    assign req.ready = (ctrl.op == OP_TAKE);
    assign accept    = req.valid && (ctrl.op == OP_TAKE);
    assign cfg.ready = 1'b1;

    // Compare and index arithmetic
    assign hit     = (rdata_reg == val_reg);
    assign idx_inc = idx_reg + CW'(1);

    // Saturate capacity into 1..DEPTH
    assign cap_wide = CMP_W'(cap_reg);
    assign cap_eff  = (cap_wide == '0) ? CMP_W'(1) :
                      (cap_wide > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_wide;
    assign full     = (CMP_W'(count_reg) >= cap_eff);
    assign empty    = (count_reg == '0);
    assign out_busy = rsp_valid_reg && !rsp.ready;

    // Decode the held request
    assign k_ins  = (kind_reg == KIND_INSERT);
    assign k_srch = (kind_reg == KIND_SEARCH);
    assign k_rem  = (kind_reg == KIND_REMOVE);

    // Flags for the sequencer
    assign flags.no_req    = !req.valid;
    assign flags.k_ins     = k_ins;
    assign flags.k_srch    = k_srch;
    assign flags.k_nop     = !(k_ins || k_srch || k_rem);
    assign flags.rem_empty = k_rem && empty;
    assign flags.idx_end   = (idx_reg == count_reg);
    assign flags.miss      = !hit;
    assign flags.shift_end = (idx_inc == count_reg);
    assign flags.full      = full;
    assign flags.out_busy  = out_busy;

    // Memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = rdata_reg;
        mem_raddr = idx_reg[AW-1:0];
        unique case (ctrl.op)
            OP_APPEND:
            begin
                mem_we    = 1'b1;
                mem_waddr = count_reg[AW-1:0];
                mem_wdata = val_reg;
            end
            OP_SHIFT:
            begin
                mem_we = 1'b1;
            end
            OP_READ_NEXT:
            begin
                mem_raddr = idx_inc[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Working register updates
    always_comb
    begin
        kind_next   = kind_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        cap_next    = cap_reg;

        unique case (ctrl.op)
            OP_TAKE:
            begin
                if (accept)
                begin
                    kind_next   = req.kind;
                    val_next    = VALUE_BITS'(req.value);
                    idx_next    = '0;
                    status_next = ST_DONE;
                    pos_next    = '0;
                end
            end
            OP_ADVANCE:
            begin
                if (!hit)
                begin
                    idx_next = idx_inc;
                end
            end
            OP_SET_POS:   pos_next    = POS_W'(idx_reg);
            OP_SHIFT:     idx_next    = idx_inc;
            OP_DEC:       count_next  = count_reg - CW'(1);
            OP_APPEND:    count_next  = count_reg + CW'(1);
            OP_ST_FULL:   status_next = ST_FULL;
            OP_ST_EMPTY:  status_next = ST_EMPTY;
            OP_ST_MISS:   status_next = ST_MISS;
            default:
            begin
            end
        endcase

        // Capacity writes must come only while idle; the block does not enforce this
        if (cfg.valid)
        begin
            cap_next = cfg.capacity;
        end
    end

    // Load the output register on emit, drop valid once taken
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_fill_next   = rsp_fill_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_full_next   = rsp_full_reg;
        if ((ctrl.op == OP_EMIT) && !out_busy)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = status_reg;
            rsp_pos_next    = pos_reg;
            rsp_fill_next   = FILL_W'(count_reg);
            rsp_empty_next  = empty;
            rsp_full_next   = full;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.position   = rsp_pos_reg;
    assign rsp.fill_count = rsp_fill_reg;
    assign rsp.is_empty   = rsp_empty_reg;
    assign rsp.is_full    = rsp_full_reg;

    // Entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        rsp_status_reg <= rsp_status_next;
        rsp_pos_reg    <= rsp_pos_next;
        rsp_fill_reg   <= rsp_fill_next;
        rsp_empty_reg  <= rsp_empty_next;
        rsp_full_reg   <= rsp_full_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/compacting_value_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_value_table_unit: packed value table with insert/search/remove
// Microcoded sequencer driving a datapath around an entry memory with one write and one registered read port.
//
//   channel | dir | beat contents
//   --------+-----+---------------------------------------------------------
//   req     | in  | kind, value
//   rsp     | out | status, position, fill_count, is_empty, is_full
//   cfg     | in  | capacity (always ready)
//
// Each entry compared costs a read and a compare step, and each entry moved a
// read and a shift step, since the entry memory read is registered. One
// request is in work at a time; the result register lets the next beat be
// accepted while the previous result waits. A stalled rsp holds the program at
// its emit step. Reset clears the fill count and sets capacity to 16; entry
// contents are not cleared.
// ----------------------------------------------------------------------------
module compacting_value_table_unit #(
    parameter int DEPTH      = cvt_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = cvt_pkg::VALUE_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cvt_req_if.sink     req,
    cvt_rsp_if.source   rsp,
    cvt_cfg_if.sink     cfg
);
    import cvt_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    // Program sequencer
    cvt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Table datapath
    cvt_dpath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .flags (flags),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/cvt_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_chk: port-level checker for the compacting value table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module cvt_chk (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [cvt_pkg::STAT_W-1:0] rsp_status,
    input wire logic [cvt_pkg::POS_W-1:0]  rsp_position,
    input wire logic                       rsp_is_empty,
    input wire logic                       rsp_is_full
);
    import cvt_pkg::*;

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position))
        else $error("stalled result changed or dropped");

    // One request in work: no second beat right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on two consecutive cycles");

    // Capacity is at least one, so a full table is never empty
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_full |-> !rsp_is_empty)
        else $error("result flags full and empty together");

    // An empty-table report leaves the table empty
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_is_empty && (rsp_position == '0))
        else $error("empty status with a non-empty table");

    // Full and empty reports carry no position
    a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ST_FULL) || (rsp_status == ST_EMPTY))
        |-> (rsp_position == '0))
        else $error("position set on a full or empty result");

endmodule

bind compacting_value_table_unit cvt_chk u_cvt_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_position (rsp.position),
    .rsp_is_empty (rsp.is_empty),
    .rsp_is_full  (rsp.is_full)
);
`default_nettype wire
